FILE: src/tsb_pkg.sv
`timescale 1ns / 1ps

package tsb_pkg;

  // Defaults for the top level parameters
  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int MAX_RADIUS_DEF  = 16;
  localparam int WEIGHT_BITS_DEF = 16;

  // Fixed field widths
  localparam int ROW_W   = 12;
  localparam int HGT_W   = 13;
  localparam int SIG_W   = 11;
  localparam int CFG_W   = 13;
  localparam int PIX_W   = 32;
  localparam int DEN_W   = 22;
  localparam int EXP_W   = 17;
  localparam int MAX_HEIGHT = 4096;

  // Sigma of 0.7 pixel in Q8; below it a pixel passes unchanged
  localparam int SIGMA_MIN = 180;
  // 1/sqrt(2*pi) in Q24
  localparam int INV_SQRT_2PI_Q24 = 6693141;
  // i^2/(2 sigma^2) in Q4 with sigma in Q8: scale of i^2 is 2^19
  localparam int T_SHIFT = 19;
  // Integer part of the exponent at which exp(-n) reads zero
  localparam int EXP_LIMIT = 12;

  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH,
    CFG_IMAGE_HEIGHT,
    CFG_FAR_END_ROW,
    CFG_FAR_RAMP_END_ROW,
    CFG_SHARP_END_ROW,
    CFG_NEAR_RAMP_END_ROW,
    CFG_SIGMA_FAR,
    CFG_SIGMA_NEAR
  } cfg_index_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BAND,
    ST_BAND_WAIT,
    ST_SIGMA,
    ST_WT_T,
    ST_WT_TW,
    ST_WT_E,
    ST_WT_X,
    ST_WT_W,
    ST_WT_WW,
    ST_HSTART,
    ST_COL,
    ST_VERT,
    ST_VDRAIN,
    ST_VLATCH,
    ST_HADD,
    ST_HNEXT,
    ST_HDONE,
    ST_PASS,
    ST_PASS_W,
    ST_EMIT
  } state_t;

  // exp(-n) in Q16
  function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] n);
    logic [EXP_W-1:0] v;
    case (n)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // exp(-f/16) in Q16
  function automatic logic [EXP_W-1:0] exp_frac(input logic [3:0] f);
    logic [EXP_W-1:0] v;
    case (f)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd61565;
      4'd2:    v = 17'd57835;
      4'd3:    v = 17'd54331;
      4'd4:    v = 17'd51039;
      4'd5:    v = 17'd47947;
      4'd6:    v = 17'd45042;
      4'd7:    v = 17'd42313;
      4'd8:    v = 17'd39750;
      4'd9:    v = 17'd37341;
      4'd10:   v = 17'd35079;
      4'd11:   v = 17'd32954;
      4'd12:   v = 17'd30957;
      4'd13:   v = 17'd29081;
      4'd14:   v = 17'd27319;
      4'd15:   v = 17'd25664;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/tsb_if.sv
`timescale 1ns / 1ps

// Input pixel channel
interface tsb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_in;
  logic        pad;

  modport source (output valid, output pixel_in, output pad, input ready);
  modport sink   (input valid, input pixel_in, input pad, output ready);
endinterface

// Output pixel channel
interface tsb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic        frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

FILE: src/tsb_ram.sv
`timescale 1ns / 1ps

module tsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/tsb_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module tsb_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 22
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  // Shift in the next numerator bit and try the subtraction
  always_comb begin
    rem_sh = {rem[DEN_W-1:0], quot[NUM_W-1]};
    fits   = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(NUM_W);
        rem   <= '0;
        quot  <= num;
        den_q <= den;
      end else if (busy) begin
        rem  <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
        quot <= {quot[NUM_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/tsb_mac.sv
`timescale 1ns / 1ps

// Four channel multiply-accumulate with final shift and saturation
module tsb_mac #(
  parameter int WEIGHT_BITS = 16,
  parameter int TAPS_W = 6
) (
  input  logic                   clk,
  input  logic                   clr,
  input  logic                   add,
  input  logic [31:0]            pix,
  input  logic [WEIGHT_BITS-1:0] wt,
  output logic [31:0]            result
);

  localparam int ACC_W = 8 + WEIGHT_BITS + TAPS_W;
  localparam int F = WEIGHT_BITS - 1;

  logic [ACC_W-1:0] acc [4];
  logic [ACC_W-1:0] v;

  // Accumulate each channel times the tap weight
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 4; ch++) begin
      if (clr) begin
        acc[ch] <= '0;
      end else if (add) begin
        acc[ch] <= acc[ch] + ACC_W'(pix[8*ch +: 8] * wt);
      end
    end
  end

  // Drop the fraction once, clamp at 255
  always_comb begin
    v = '0;
    for (int ch = 0; ch < 4; ch++) begin
      v = acc[ch] >> F;
      result[8*ch +: 8] = (v > ACC_W'(255)) ? 8'hff : v[7:0];
    end
  end

endmodule

FILE: src/tilt_shift_separable_gaussian_blur_top.sv
`timescale 1ns / 1ps

// Tilt-shift blur of an ARGB raster stream. Pixels are written into a ring of
// 2*MAX_RADIUS+2 input rows held in one line memory; a blurred pixel comes out
// once MAX_RADIUS+1 rows beyond it have arrived, and pad beats at the start of
// a frame push out the last rows. A blurred pixel with radius r is built by one
// sequencer reading one line-memory word per cycle in each vertical column pass;
// a ramp row first waits for the divider to scale its sigma, and when sigma or
// the radius changes from the last blurred pixel, the tap weights are rebuilt
// through the shared serial divider. The line memory needs no clearing pass
// after reset.
module tilt_shift_separable_gaussian_blur_top #(
  parameter int MAX_WIDTH   = tsb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS  = tsb_pkg::MAX_RADIUS_DEF,
  parameter int WEIGHT_BITS = tsb_pkg::WEIGHT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [tsb_pkg::CFG_W-1:0] cfg_data,
  tsb_in_if.sink                    in_ch,
  tsb_out_if.source                 out_ch
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = COL_W + 1;
  localparam int RING   = 2 * MAX_RADIUS + 2;
  localparam int SLOT_W = $clog2(RING);
  localparam int ADDR_W = SLOT_W + COL_W;
  localparam int DEPTH  = RING * (2 ** COL_W);
  localparam int R_W    = $clog2(MAX_RADIUS + 1);
  localparam int K_W    = $clog2(2 * MAX_RADIUS + 1);
  localparam int F      = WEIGHT_BITS - 1;
  localparam int NUM_A  = 2 * R_W + tsb_pkg::T_SHIFT;
  localparam int NUM_B  = F + 8;
  localparam int NUM_W  = (NUM_A > NUM_B) ? NUM_A : NUM_B;
  localparam int PEND_W = $clog2((MAX_RADIUS + 1) * MAX_WIDTH + 2);
  localparam int SCOL_W = ((COL_W > R_W) ? COL_W : R_W) + 2;
  localparam int SROW_W = tsb_pkg::ROW_W + 2;
  localparam int ROW_W  = tsb_pkg::ROW_W;
  localparam int HGT_W  = tsb_pkg::HGT_W;
  localparam int SIG_W  = tsb_pkg::SIG_W;
  localparam int DEN_W  = tsb_pkg::DEN_W;
  localparam int EXP_W  = tsb_pkg::EXP_W;
  localparam int X_W    = 40;

  // Configuration registers
  logic [11:0]      image_width;
  logic [12:0]      image_height;
  logic [ROW_W-1:0] far_end_row, far_ramp_end_row, sharp_end_row, near_ramp_end_row;
  logic [SIG_W-1:0] sigma_far, sigma_near;

  tsb_pkg::state_t state, state_next;

  logic [COL_W-1:0]  in_column, out_column;
  logic [ROW_W-1:0]  in_row, out_row;
  logic [SLOT_W-1:0] in_slot, out_slot;
  logic [PEND_W-1:0] pending, pend_inc, lat;
  logic [WID_W-1:0]  w_eff;
  logic [HGT_W-1:0]  h_eff;
  logic              emit_now, pad_flush;

  logic [SIG_W-1:0]   s_q, base_q, wt_s;
  logic [R_W-1:0]     r_q, r_new, wt_r, wi;
  logic               wt_ok, cache_hit;
  logic [12:0]        r_sum;
  logic [NUM_W-1:0]   t_q;
  logic [EXP_W-1:0]   e_q;
  logic [X_W-1:0]     x_q;
  logic [WEIGHT_BITS-1:0] wts [MAX_RADIUS + 1];
  logic [WEIGHT_BITS-1:0] wt_rd, tap_wt;
  logic [R_W-1:0]     wt_idx;
  logic [K_W-1:0]     k, kk, two_r, vd, hd;
  logic [SCOL_W-1:0]  hcol;
  logic [SROW_W-1:0]  vrow;
  logic [SLOT_W-1:0]  vslot;
  logic [SLOT_W:0]    vslot_init;
  logic               h_in, v_in, tap_live;
  logic [31:0]        vres, res_pix, vmac_result, hmac_result;
  logic               out_valid, out_last;
  logic [31:0]        out_pix;
  logic               in_far, in_far_ramp, in_sharp, in_near_ramp;

  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_num, div_quot;
  logic [DEN_W-1:0]   div_den;

  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [31:0]        ram_rdata;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width       <= 12'd2048;
      image_height      <= 13'd1;
      far_end_row       <= '0;
      far_ramp_end_row  <= '0;
      sharp_end_row     <= '0;
      near_ramp_end_row <= '0;
      sigma_far         <= '0;
      sigma_near        <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tsb_pkg::CFG_IMAGE_WIDTH:       image_width       <= cfg_data[11:0];
        tsb_pkg::CFG_IMAGE_HEIGHT:      image_height      <= cfg_data[12:0];
        tsb_pkg::CFG_FAR_END_ROW:       far_end_row       <= cfg_data[ROW_W-1:0];
        tsb_pkg::CFG_FAR_RAMP_END_ROW:  far_ramp_end_row  <= cfg_data[ROW_W-1:0];
        tsb_pkg::CFG_SHARP_END_ROW:     sharp_end_row     <= cfg_data[ROW_W-1:0];
        tsb_pkg::CFG_NEAR_RAMP_END_ROW: near_ramp_end_row <= cfg_data[ROW_W-1:0];
        tsb_pkg::CFG_SIGMA_FAR:         sigma_far         <= cfg_data[SIG_W-1:0];
        tsb_pkg::CFG_SIGMA_NEAR:        sigma_near        <= cfg_data[SIG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size and output latency in pixels
  always_comb begin
    if (image_width == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HGT_W'(1);
    end else if (image_height > HGT_W'(tsb_pkg::MAX_HEIGHT)) begin
      h_eff = HGT_W'(tsb_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
    lat       = PEND_W'(MAX_RADIUS + 1) * PEND_W'(w_eff);
    pend_inc  = pending + 1'b1;
    emit_now  = pend_inc > lat;
    pad_flush = (in_row == '0) && (in_column == '0) && (pending != '0);
  end

  // Band of the output row and radius of its blur
  always_comb begin
    in_far       = out_row <= far_end_row;
    in_far_ramp  = out_row <= far_ramp_end_row;
    in_sharp     = out_row <= sharp_end_row;
    in_near_ramp = out_row <= near_ramp_end_row;
    r_sum = 13'(3 * base_q + 255);
    if (int'(r_sum[12:8]) > MAX_RADIUS) begin
      r_new = R_W'(MAX_RADIUS);
    end else begin
      r_new = R_W'(r_sum[12:8]);
    end
    cache_hit = wt_ok && (wt_s == s_q) && (wt_r == r_new);
  end

  // Tap indexing for both passes, one weight read port
  always_comb begin
    two_r  = K_W'(r_q) << 1;
    vd     = (kk < K_W'(r_q)) ? K_W'(r_q) - kk : kk - K_W'(r_q);
    hd     = (k < K_W'(r_q)) ? K_W'(r_q) - k : k - K_W'(r_q);
    wt_idx = (state == tsb_pkg::ST_HADD) ? hd[R_W-1:0] : vd[R_W-1:0];
    wt_rd  = wts[wt_idx];
    h_in   = !hcol[SCOL_W-1] && (hcol[SCOL_W-2:0] < (SCOL_W - 1)'(w_eff));
    v_in   = !vrow[SROW_W-1] && (vrow[SROW_W-2:0] < (SROW_W - 1)'(h_eff));
    vslot_init = (SLOT_W + 1)'(out_slot) + (SLOT_W + 1)'(RING) - (SLOT_W + 1)'(r_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, divider and memory read control
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    ram_re     = 1'b0;
    ram_raddr  = {vslot, hcol[COL_W-1:0]};
    case (state)
      tsb_pkg::ST_IDLE: begin
        if (in_ch.valid && ((!in_ch.pad && emit_now) || (in_ch.pad && pad_flush))) begin
          state_next = tsb_pkg::ST_BAND;
        end
      end
      tsb_pkg::ST_BAND: begin
        if (in_far) begin
          state_next = tsb_pkg::ST_SIGMA;
        end else if (in_far_ramp) begin
          div_start  = 1'b1;
          div_num    = NUM_W'(sigma_far) * NUM_W'(far_ramp_end_row - out_row);
          div_den    = DEN_W'(far_ramp_end_row - far_end_row);
          state_next = tsb_pkg::ST_BAND_WAIT;
        end else if (in_sharp) begin
          state_next = tsb_pkg::ST_PASS;
        end else if (in_near_ramp) begin
          div_start  = 1'b1;
          div_num    = NUM_W'(sigma_near) * NUM_W'(out_row - sharp_end_row);
          div_den    = DEN_W'(near_ramp_end_row - sharp_end_row);
          state_next = tsb_pkg::ST_BAND_WAIT;
        end else begin
          state_next = tsb_pkg::ST_SIGMA;
        end
      end
      tsb_pkg::ST_BAND_WAIT: begin
        if (div_done) begin
          state_next = tsb_pkg::ST_SIGMA;
        end
      end
      tsb_pkg::ST_SIGMA: begin
        if (s_q < SIG_W'(tsb_pkg::SIGMA_MIN)) begin
          state_next = tsb_pkg::ST_PASS;
        end else if (cache_hit) begin
          state_next = tsb_pkg::ST_HSTART;
        end else begin
          state_next = tsb_pkg::ST_WT_T;
        end
      end
      tsb_pkg::ST_WT_T: begin
        div_start  = 1'b1;
        div_num    = (NUM_W'(wi) * NUM_W'(wi)) << tsb_pkg::T_SHIFT;
        div_den    = DEN_W'(s_q) * DEN_W'(s_q);
        state_next = tsb_pkg::ST_WT_TW;
      end
      tsb_pkg::ST_WT_TW: begin
        if (div_done) begin
          state_next = tsb_pkg::ST_WT_E;
        end
      end
      tsb_pkg::ST_WT_E: state_next = tsb_pkg::ST_WT_X;
      tsb_pkg::ST_WT_X: state_next = tsb_pkg::ST_WT_W;
      tsb_pkg::ST_WT_W: begin
        div_start  = 1'b1;
        div_num    = NUM_W'(x_q >> (32 - F));
        div_den    = DEN_W'(s_q);
        state_next = tsb_pkg::ST_WT_WW;
      end
      tsb_pkg::ST_WT_WW: begin
        if (div_done) begin
          state_next = (wi == r_q) ? tsb_pkg::ST_HSTART : tsb_pkg::ST_WT_T;
        end
      end
      tsb_pkg::ST_HSTART: state_next = tsb_pkg::ST_COL;
      tsb_pkg::ST_COL: begin
        state_next = h_in ? tsb_pkg::ST_VERT : tsb_pkg::ST_HNEXT;
      end
      tsb_pkg::ST_VERT: begin
        ram_re = v_in;
        if (kk == two_r) begin
          state_next = tsb_pkg::ST_VDRAIN;
        end
      end
      tsb_pkg::ST_VDRAIN: state_next = tsb_pkg::ST_VLATCH;
      tsb_pkg::ST_VLATCH: state_next = tsb_pkg::ST_HADD;
      tsb_pkg::ST_HADD:   state_next = tsb_pkg::ST_HNEXT;
      tsb_pkg::ST_HNEXT: begin
        state_next = (k == two_r) ? tsb_pkg::ST_HDONE : tsb_pkg::ST_COL;
      end
      tsb_pkg::ST_HDONE: state_next = tsb_pkg::ST_EMIT;
      tsb_pkg::ST_PASS: begin
        ram_re     = 1'b1;
        ram_raddr  = {out_slot, out_column};
        state_next = tsb_pkg::ST_PASS_W;
      end
      tsb_pkg::ST_PASS_W: state_next = tsb_pkg::ST_EMIT;
      tsb_pkg::ST_EMIT: begin
        if (!out_valid || out_ch.ready) begin
          state_next = tsb_pkg::ST_IDLE;
        end
      end
      default: state_next = tsb_pkg::ST_IDLE;
    endcase
  end

  // Store each input pixel into its ring row
  assign in_ch.ready = (state == tsb_pkg::ST_IDLE);
  assign ram_we      = in_ch.valid && in_ch.ready && !in_ch.pad;
  assign ram_waddr   = {in_slot, in_column};

  // Datapath and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      in_slot    <= '0;
      out_column <= '0;
      out_row    <= '0;
      out_slot   <= '0;
      pending    <= '0;
      wt_ok      <= 1'b0;
      tap_live   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready && state != tsb_pkg::ST_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        tsb_pkg::ST_IDLE: begin
          if (in_ch.valid) begin
            if (!in_ch.pad) begin
              if (WID_W'(in_column) + 1'b1 >= w_eff) begin
                in_column <= '0;
                in_slot   <= (in_slot == SLOT_W'(RING - 1)) ? '0 : in_slot + 1'b1;
                in_row    <= (HGT_W'(in_row) + 1'b1 >= h_eff) ? '0 : in_row + 1'b1;
              end else begin
                in_column <= in_column + 1'b1;
              end
              if (!emit_now) begin
                pending <= pend_inc;
              end
            end else if (pad_flush) begin
              pending <= pending - 1'b1;
            end
          end
        end
        tsb_pkg::ST_BAND: begin
          base_q <= (in_far || in_far_ramp) ? sigma_far : sigma_near;
          if (in_far) begin
            s_q <= sigma_far;
          end else begin
            s_q <= sigma_near;
          end
        end
        tsb_pkg::ST_BAND_WAIT: begin
          if (div_done) begin
            s_q <= div_quot[SIG_W-1:0];
          end
        end
        tsb_pkg::ST_SIGMA: begin
          r_q <= r_new;
          wi  <= '0;
          if (!cache_hit) begin
            wt_ok <= 1'b0;
          end
        end
        tsb_pkg::ST_WT_TW: begin
          if (div_done) begin
            t_q <= div_quot;
          end
        end
        tsb_pkg::ST_WT_E: begin
          if (t_q[NUM_W-1:4] < (NUM_W - 4)'(tsb_pkg::EXP_LIMIT)) begin
            e_q <= EXP_W'((34'(tsb_pkg::exp_int(t_q[7:4]))
                   * 34'(tsb_pkg::exp_frac(t_q[3:0]))) >> 16);
          end else begin
            e_q <= '0;
          end
        end
        tsb_pkg::ST_WT_X: begin
          x_q <= X_W'(tsb_pkg::INV_SQRT_2PI_Q24) * X_W'(e_q);
        end
        tsb_pkg::ST_WT_WW: begin
          if (div_done) begin
            wts[wi] <= div_quot[WEIGHT_BITS-1:0];
            if (wi == r_q) begin
              wt_ok <= 1'b1;
              wt_s  <= s_q;
              wt_r  <= r_q;
            end else begin
              wi <= wi + 1'b1;
            end
          end
        end
        tsb_pkg::ST_HSTART: begin
          k    <= '0;
          hcol <= SCOL_W'(out_column) - SCOL_W'(r_q);
        end
        tsb_pkg::ST_COL: begin
          kk       <= '0;
          vrow     <= SROW_W'(out_row) - SROW_W'(r_q);
          vslot    <= (vslot_init >= (SLOT_W + 1)'(RING))
                      ? SLOT_W'(vslot_init - (SLOT_W + 1)'(RING)) : SLOT_W'(vslot_init);
          tap_live <= 1'b0;
        end
        tsb_pkg::ST_VERT: begin
          tap_live <= v_in;
          tap_wt   <= wt_rd;
          kk       <= kk + 1'b1;
          vrow     <= vrow + 1'b1;
          vslot    <= (vslot == SLOT_W'(RING - 1)) ? '0 : vslot + 1'b1;
        end
        tsb_pkg::ST_VDRAIN: tap_live <= 1'b0;
        tsb_pkg::ST_VLATCH: vres <= vmac_result;
        tsb_pkg::ST_HNEXT: begin
          k    <= k + 1'b1;
          hcol <= hcol + 1'b1;
        end
        tsb_pkg::ST_HDONE:  res_pix <= hmac_result;
        tsb_pkg::ST_PASS_W: res_pix <= ram_rdata;
        tsb_pkg::ST_EMIT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_pix   <= res_pix;
            out_last  <= (WID_W'(out_column) + 1'b1 >= w_eff)
                         && (HGT_W'(out_row) + 1'b1 >= h_eff);
            if (WID_W'(out_column) + 1'b1 >= w_eff) begin
              out_column <= '0;
              out_slot   <= (out_slot == SLOT_W'(RING - 1)) ? '0 : out_slot + 1'b1;
              out_row    <= (HGT_W'(out_row) + 1'b1 >= h_eff) ? '0 : out_row + 1'b1;
            end else begin
              out_column <= out_column + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.pixel_out  = out_pix;
  assign out_ch.frame_last = out_last;

  tsb_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.pixel_in),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tsb_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Vertical pass over one column of the window
  tsb_mac #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .TAPS_W      (K_W)
  ) u_vmac (
    .clk    (clk),
    .clr    (state == tsb_pkg::ST_COL),
    .add    (tap_live && (state == tsb_pkg::ST_VERT || state == tsb_pkg::ST_VDRAIN)),
    .pix    (ram_rdata),
    .wt     (tap_wt),
    .result (vmac_result)
  );

  // Horizontal pass over the vertical results
  tsb_mac #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .TAPS_W      (K_W)
  ) u_hmac (
    .clk    (clk),
    .clr    (state == tsb_pkg::ST_HSTART),
    .add    (state == tsb_pkg::ST_HADD),
    .pix    (vres),
    .wt     (wt_rd),
    .result (hmac_result)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int MAXW   = tsb_pkg::MAX_WIDTH_DEF;
  localparam int RADMAX = tsb_pkg::MAX_RADIUS_DEF;
  localparam int FRAC   = tsb_pkg::WEIGHT_BITS_DEF - 1;
  localparam int RING   = 2 * RADMAX + 2;

  typedef struct {
    logic [31:0] pixel;
    logic        last;
  } blur_px_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [tsb_pkg::CFG_W-1:0] cfg_data = '0;

  tsb_in_if  in_ch();
  tsb_out_if out_ch();

  tilt_shift_separable_gaussian_blur_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the blur settings and pipeline state
  int unsigned img_w, img_h, far_end, far_ramp_end, sharp_end, near_ramp_end;
  int unsigned sig_far, sig_near;
  logic [31:0] line_ring [RING*MAXW];
  longint unsigned wt [RADMAX+1];
  int unsigned in_col, in_row, out_col, out_row, in_slot, out_slot, pending;

  blur_px_t expected_px[$];
  int mismatches = 0;
  int pixels_sent = 0;
  bit steady = 1'b0;
  bit rx_hold = 1'b0;
  int rx_hold_len = 0;

  longint unsigned exp_whole [12] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22,
                                      8, 3, 1};
  longint unsigned exp_part [16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
                                     42313, 39750, 37341, 35079, 32954, 30957, 29081,
                                     27319, 25664};

  function automatic int unsigned eff_w();
    if (img_w == 0) return 1;
    return (img_w > MAXW) ? MAXW : img_w;
  endfunction

  function automatic int unsigned eff_h();
    if (img_h == 0) return 1;
    return (img_h > tsb_pkg::MAX_HEIGHT) ? tsb_pkg::MAX_HEIGHT : img_h;
  endfunction

  // Pick sigma and radius for a row; 0 means the row stays sharp
  function automatic bit row_sigma(int unsigned y, output int unsigned s, output int r);
    int unsigned sv, base;
    s = 0;
    r = 0;
    if (y <= far_end) begin
      sv = sig_far; base = sig_far;
    end else if (y <= far_ramp_end) begin
      sv = sig_far * (far_ramp_end - y) / (far_ramp_end - far_end); base = sig_far;
    end else if (y <= sharp_end) begin
      return 1'b0;
    end else if (y <= near_ramp_end) begin
      sv = sig_near * (y - sharp_end) / (near_ramp_end - sharp_end); base = sig_near;
    end else begin
      sv = sig_near; base = sig_near;
    end
    if (sv < tsb_pkg::SIGMA_MIN) return 1'b0;
    base = (3 * base + 255) >> 8;
    if (base > RADMAX) base = RADMAX;
    s = sv;
    r = base;
    return 1'b1;
  endfunction

  function automatic void build_weights(int unsigned s, int r);
    longint unsigned t, e, ss;
    ss = longint'(s);
    for (int i = 0; i <= r; i++) begin
      t = (longint'(i * i) << 19) / (ss * ss);
      e = 0;
      if ((t >> 4) < 12) e = (exp_whole[t >> 4] * exp_part[t & 15]) >> 16;
      wt[i] = ((longint'(tsb_pkg::INV_SQRT_2PI_Q24) * e) << FRAC) / (ss << 32);
    end
  endfunction

  function automatic logic [31:0] weigh_taps(logic [31:0] taps [2*RADMAX+1], int r);
    longint unsigned acc [4];
    longint unsigned v;
    logic [31:0] res;
    int d;
    res = '0;
    for (int ch = 0; ch < 4; ch++) acc[ch] = 0;
    for (int k = 0; k <= 2 * r; k++) begin
      d = (k < r) ? r - k : k - r;
      for (int ch = 0; ch < 4; ch++) acc[ch] += longint'(taps[k][8*ch +: 8]) * wt[d];
    end
    for (int ch = 0; ch < 4; ch++) begin
      v = acc[ch] >> FRAC;
      if (v > 255) v = 255;
      res[8*ch +: 8] = v[7:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] ring_at(int d, int unsigned col);
    int unsigned slot;
    slot = (out_slot + RING + d) % RING;
    return line_ring[slot * MAXW + (col % MAXW)];
  endfunction

  function automatic logic [31:0] column_blur(int unsigned col, int r, int unsigned h);
    logic [31:0] taps [2*RADMAX+1];
    int row;
    for (int k = 0; k < 2 * RADMAX + 1; k++) taps[k] = '0;
    for (int k = 0; k <= 2 * r; k++) begin
      row = int'(out_row) + k - r;
      taps[k] = (row >= 0 && row < int'(h)) ? ring_at(k - r, col) : '0;
    end
    return weigh_taps(taps, r);
  endfunction

  // Produce the oldest pending pixel and advance the output position
  function automatic void emit_pixel();
    logic [31:0] hwin [2*RADMAX+1];
    int unsigned w, h, s;
    int r, c;
    blur_px_t px;
    w = eff_w();
    h = eff_h();
    if (!row_sigma(out_row, s, r)) begin
      px.pixel = ring_at(0, out_col);
    end else begin
      build_weights(s, r);
      for (int k = 0; k < 2 * RADMAX + 1; k++) hwin[k] = '0;
      for (int k = 0; k <= 2 * r; k++) begin
        c = int'(out_col) + k - r;
        hwin[k] = (c >= 0 && c < int'(w)) ? column_blur(c, r, h) : '0;
      end
      px.pixel = weigh_taps(hwin, r);
    end
    px.last = (out_col + 1 >= w && out_row + 1 >= h);
    expected_px.push_back(px);
    if (out_col + 1 >= w) begin
      out_col = 0;
      out_slot = (out_slot + 1) % RING;
      out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
    end else begin
      out_col++;
    end
    pending--;
  endfunction

  function automatic void predict_beat(logic [31:0] pix, logic pad);
    int unsigned w, h;
    w = eff_w();
    h = eff_h();
    if (!pad) begin
      line_ring[in_slot * MAXW + (in_col % MAXW)] = pix;
      if (in_col + 1 >= w) begin
        in_col = 0;
        in_slot = (in_slot + 1) % RING;
        in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
      end else begin
        in_col++;
      end
      pending++;
      if (pending > (RADMAX + 1) * w) emit_pixel();
    end else if (in_row == 0 && in_col == 0 && pending > 0) begin
      emit_pixel();
    end
  endfunction

  function automatic int idle_len();
    if (steady || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(12, 60);
    return $urandom_range(1, 4);
  endfunction

  // Write one register while the block is idle
  task automatic write_reg(tsb_pkg::cfg_index_t idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[tsb_pkg::CFG_W-1:0];
    case (idx)
      tsb_pkg::CFG_IMAGE_WIDTH:       img_w = val & 12'hfff;
      tsb_pkg::CFG_IMAGE_HEIGHT:      img_h = val & 13'h1fff;
      tsb_pkg::CFG_FAR_END_ROW:       far_end = val & 12'hfff;
      tsb_pkg::CFG_FAR_RAMP_END_ROW:  far_ramp_end = val & 12'hfff;
      tsb_pkg::CFG_SHARP_END_ROW:     sharp_end = val & 12'hfff;
      tsb_pkg::CFG_NEAR_RAMP_END_ROW: near_ramp_end = val & 12'hfff;
      tsb_pkg::CFG_SIGMA_FAR:         sig_far = val & 11'h7ff;
      tsb_pkg::CFG_SIGMA_NEAR:        sig_near = val & 11'h7ff;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_bands(int unsigned fe, int unsigned fr, int unsigned se,
                           int unsigned nr, int unsigned sf, int unsigned sn);
    write_reg(tsb_pkg::CFG_FAR_END_ROW, fe);
    write_reg(tsb_pkg::CFG_FAR_RAMP_END_ROW, fr);
    write_reg(tsb_pkg::CFG_SHARP_END_ROW, se);
    write_reg(tsb_pkg::CFG_NEAR_RAMP_END_ROW, nr);
    write_reg(tsb_pkg::CFG_SIGMA_FAR, sf);
    write_reg(tsb_pkg::CFG_SIGMA_NEAR, sn);
  endtask

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(logic [31:0] pix, logic pad);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel_in <= pix;
    in_ch.pad <= pad;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_beat(pix, pad);
    if (!pad) pixels_sent++;
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    while (expected_px.size() > 0) begin
      @(posedge clk);
      n++;
      if (n > 2000000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  endtask

  // Drop valid, wait for every pixel, then let in-flight work finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (60) @(posedge clk);
  endtask

  task automatic send_frame(int unsigned npix, bit noise);
    for (int i = 0; i < npix; i++) begin
      if (noise && $urandom_range(0, 15) == 0) send_beat($urandom, 1'b1);
      send_beat($urandom, 1'b0);
    end
  endtask

  task automatic flush_frame();
    while (pending > 0) send_beat($urandom, 1'b1);
  endtask

  task automatic set_dims(int unsigned w, int unsigned h);
    write_reg(tsb_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(tsb_pkg::CFG_IMAGE_HEIGHT, h);
  endtask

  // Sharp pass-through with extreme pixel values and pad handling
  task automatic test_sharp_extremes();
    set_bands(0, 0, 4095, 4095, 0, 0);
    set_dims(3, 2);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'hffff_ffff, 1'b0);
    send_beat(32'haaaa_aaaa, 1'b1);
    send_beat(32'h5555_5555, 1'b0);
    send_beat(32'haaaa_aaaa, 1'b0);
    send_beat(32'h8000_0001, 1'b0);
    send_beat(32'h7fff_fffe, 1'b0);
    send_beat(32'h0, 1'b1);
    flush_frame();
    send_beat(32'h0, 1'b1);
    settle();
  endtask

  // Saturating blur near the frame border, taps read zero outside
  task automatic test_border_blur();
    set_bands(4095, 4095, 4095, 4095, 300, 0);
    set_dims(4, 2);
    for (int i = 0; i < 8; i++) send_beat((i < 4) ? 32'hffff_ffff : $urandom, 1'b0);
    flush_frame();
    settle();
  endtask

  // Radius at its maximum, weights from the full sigma
  task automatic test_large_sigma();
    set_bands(4095, 4095, 4095, 4095, 1365, 1365);
    set_dims(2, 1);
    send_frame(2, 0);
    flush_frame();
    settle();
    set_bands(0, 0, 0, 0, 1365, 1365);
    set_dims(1, 2);
    send_frame(2, 0);
    flush_frame();
    settle();
  endtask

  // Every band in one frame: far, ramp down, sharp, ramp up, near
  task automatic test_bands();
    set_bands(1, 4, 6, 9, 700, 900);
    set_dims(1, 12);
    send_frame(12, 0);
    flush_frame();
    settle();
  endtask

  // Dimension registers at zero
  task automatic test_dim_extremes();
    set_bands(0, 0, 4095, 4095, 0, 0);
    set_dims(0, 0);
    send_frame(2, 0);
    flush_frame();
    settle();
  endtask

  // Hold the output off long enough to stall the input
  task automatic test_backpressure();
    set_bands(4095, 4095, 4095, 4095, 200, 0);
    set_dims(2, 24);
    rx_hold_len = 800;
    rx_hold = 1'b1;
    send_frame(48, 0);
    flush_frame();
    settle();
  endtask

  task automatic test_random();
    int unsigned w, h, b0, b1, b2, b3;
    bit paused;
    paused = 1'b0;
    while (pixels_sent < 1150) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 5);
      h = $urandom_range(1, 22);
      b0 = $urandom_range(0, h);
      b1 = b0 + $urandom_range(0, 4);
      b2 = b1 + $urandom_range(0, 4);
      b3 = b2 + $urandom_range(0, 5);
      set_bands(b0, b1, b2, b3,
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 179) : $urandom_range(180, 480),
                ($urandom_range(0, 5) == 0) ? $urandom_range(481, 800) : $urandom_range(150, 420));
      set_dims(w, h);
      steady = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 3)) begin
        send_frame(w * h, 1'b1);
        // Pause the sender once until every pixel so far has come out
        if (!paused && expected_px.size() > 0) begin
          paused = 1'b1;
          in_ch.valid <= 1'b0;
          wait_drained();
          @(posedge clk);
        end
      end
      flush_frame();
      if ($urandom_range(0, 3) == 0) send_beat($urandom, 1'b1);
      steady = 1'b0;
      settle();
    end
  endtask

  // Count out a long receiver hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        repeat (rx_hold_len) @(posedge clk);
        rx_hold = 1'b0;
      end
    end
  end

  // Accept results with random stalls and compare against the oldest prediction
  int rx_stall = 0;
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel %h last %b", out_ch.pixel_out, out_ch.frame_last);
      end else begin
        if (out_ch.pixel_out !== expected_px[0].pixel ||
            out_ch.frame_last !== expected_px[0].last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel exp %h/%b got %h/%b", expected_px[0].pixel, expected_px[0].last,
                     out_ch.pixel_out, out_ch.frame_last);
        end
        void'(expected_px.pop_front());
      end
    end
    if (rx_hold) begin
      out_ch.ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      rx_stall = idle_len();
    end
  end

  initial begin
    #60ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pixel_in = '0;
    in_ch.pad = 1'b0;
    out_ch.ready = 1'b0;
    img_w = MAXW; img_h = 1;
    far_end = 0; far_ramp_end = 0; sharp_end = 0; near_ramp_end = 0;
    sig_far = 0; sig_near = 0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    in_slot = 0; out_slot = 0; pending = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_sharp_extremes();
    test_border_blur();
    test_large_sigma();
    test_bands();
    test_dim_extremes();
    test_backpressure();
    test_random();
    settle();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_px.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
